FILE: sv/avg_pool_2d_stream_defines.svh
// Assertion macros shared by the average pooling block.
`ifndef AVG_POOL_2D_STREAM_DEFINES_SVH
`define AVG_POOL_2D_STREAM_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define AVGP_ASSERT_IMPL(name, cond, conseq) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (conseq)) \
        else $error("avgp: same-cycle check failed");
// next-cycle implication, checked outside reset
`define AVGP_ASSERT_NEXT(name, cond, conseq) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error("avgp: next-cycle check failed");
`else
`define AVGP_ASSERT_IMPL(name, cond, conseq)
`define AVGP_ASSERT_NEXT(name, cond, conseq)
`endif
`endif

FILE: sv/avgp_pkg.sv
// Shared types and constants of the average pooling block.
package avgp_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_KERNEL  = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    // configuration port
    localparam int REG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_WIDTH_BITS  = 9;
    localparam int CFG_KERNEL_BITS = 5;
    localparam int CFG_CHAN_BITS   = 11;

    localparam logic [CFG_WIDTH_BITS-1:0]  RST_INPUT_WIDTH   = 9'd8;
    localparam logic [CFG_KERNEL_BITS-1:0] RST_KERNEL_SIZE   = 5'd2;
    localparam logic [CFG_CHAN_BITS-1:0]   RST_CHANNEL_COUNT = 11'd1;

    localparam int MAX_CHANNELS = 1024;
    localparam int CHAN_IDX_W   = 10;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_INPUT_WIDTH   = 2'd0,
        REG_KERNEL_SIZE   = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } t_reg_idx;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // sample transfer this cycle
        logic accumulate;  // read data is back, update the column sum
        logic start_div;   // window complete, start the mean division
        logic load_out;    // quotient ready, load the output register
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic emit;        // latched sample closes a window
        logic div_busy;
        logic out_free;    // output register can take a new result
    } t_ctrl_stat;

endpackage

FILE: sv/avg_pool_2d_stream.sv
// Top level of the streaming 2-D average pooling block (stride equal to kernel).
//
// Input stream: one signed Q8.8 sample per transfer, channel after channel, each
// square channel in raster order. Output stream: one window mean per completed
// KxK window, truncated toward zero, with end-of-row and end-of-channel in tuser
// and end-of-frame on tlast. Rows and columns past the last whole window are
// consumed without output; with K wider than the channel nothing is emitted.
// Configuration: a separate write channel, ready outside reset; any write restarts
// the frame (positions and column sums cleared) in the same cycle.
// Sequence: a sample that completes no window is transferred, then its column sum
// gets a read-modify-write in the sum memory before the next sample is taken. A sample
// closing a window also runs the shift-subtract divider, one quotient bit a cycle
// over SAMPLE_BITS + 2*clog2(MAX_KERNEL) bits (24 by default): the result is loaded
// into the output register once the divider is done and the register is free, and
// the next sample is taken after that load.
// Reset: synchronous, active low; tready is low during reset and the cycle after,
// configuration returns to width 8, kernel 2, one channel.
// Stall: the output register holds its result while the sink stalls; the block
// keeps taking samples that complete no window and waits only when a new mean
// is ready while the previous one is still pending.
module avg_pool_2d_stream #(
    parameter int MAX_WIDTH   = avgp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL  = avgp_pkg::DEF_MAX_KERNEL,
    parameter int SAMPLE_BITS = avgp_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample stream in
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] i_s_tdata,  // sample
    // mean stream out
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] o_m_tdata,  // average
    output logic [1:0]                      o_m_tuser,  // end_of_channel, end_of_row
    output logic                            o_m_tlast,  // end_of_frame
    // register writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [avgp_pkg::REG_IDX_W-1:0]  i_cfg_index,
    input  logic [avgp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    avgp_pkg::t_ctrl_cmd  cmd;
    avgp_pkg::t_ctrl_stat stat;

    // register writes are taken whenever reset is released
    assign o_cfg_ready = i_rst_n;

    avgp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    avgp_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_KERNEL  (MAX_KERNEL),
        .SAMPLE_BITS (SAMPLE_BITS),
        .TDATA_W     (TDATA_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_sample    (i_s_tdata[SAMPLE_BITS-1:0]),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

FILE: sv/avgp_div.sv
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
module avgp_div #(
    parameter int SW = 24,
    parameter int DW = 9,
    parameter int QW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [SW-1:0] i_dividend,
    input  logic        [DW-1:0] i_divisor,
    output logic                 o_busy,
    output logic signed [QW-1:0] o_quotient
);

    localparam int CW = $clog2(SW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic          r_neg;

    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_diff;
    logic          rem_ge;
    logic [SW-1:0] dvd_mag;

    // restoring step
    always_comb begin
        rem_sh   = {r_rem, r_q[SW-1]};
        rem_diff = rem_sh - {1'b0, r_d};
        rem_ge   = rem_sh >= {1'b0, r_d};
        dvd_mag  = i_dividend[SW-1] ? (SW'(0) - $unsigned(i_dividend)) : $unsigned(i_dividend);
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(SW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // quotient and remainder shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= dvd_mag;
            r_rem <= '0;
            r_d   <= i_divisor;
            r_neg <= i_dividend[SW-1];
        end else if (r_busy) begin
            r_rem <= rem_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
            r_q   <= {r_q[SW-2:0], rem_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = QW'(r_neg ? (SW'(0) - r_q) : r_q);

endmodule

FILE: sv/avgp_ctrl.sv
// Controller state machine: sample intake, accumulate, divide, hand off.
`include "avg_pool_2d_stream_defines.svh"
module avgp_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  avgp_pkg::t_ctrl_stat   i_stat,
    output avgp_pkg::t_ctrl_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    // commands decoded from state
    always_comb begin
        o_cmd.accept     = r_in_ready & i_s_tvalid;
        o_cmd.accumulate = (r_state == S_ACC);
        o_cmd.start_div  = (r_state == S_ACC) & i_stat.emit;
        o_cmd.load_out   = (r_state == S_DIV) & !i_stat.div_busy & i_stat.out_free;
    end

    assign o_s_tready = r_in_ready;

    // state and ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.accept) begin
                        r_state    <= S_ACC;
                        r_in_ready <= 1'b0;
                    end else begin
                        r_in_ready <= 1'b1;
                    end
                end
                S_ACC: begin
                    if (i_stat.emit) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (o_cmd.load_out) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b0;
                end
            endcase
        end
    end

    `AVGP_ASSERT_NEXT(a_accept_to_acc, o_cmd.accept, r_state == S_ACC && !r_in_ready)
    `AVGP_ASSERT_NEXT(a_start_sets_busy, o_cmd.start_div, i_stat.div_busy)
    `AVGP_ASSERT_IMPL(a_ready_only_idle, r_state != S_IDLE, !r_in_ready)

endmodule

FILE: sv/avgp_dp.sv
// Datapath: configuration, position counters, column sum memory, divider, output register.
`include "avg_pool_2d_stream_defines.svh"
module avgp_dp #(
    parameter int MAX_WIDTH   = avgp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL  = avgp_pkg::DEF_MAX_KERNEL,
    parameter int SAMPLE_BITS = avgp_pkg::DEF_SAMPLE_BITS,
    parameter int TDATA_W     = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [avgp_pkg::REG_IDX_W-1:0]    i_cfg_index,
    input  logic [avgp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  avgp_pkg::t_ctrl_cmd               i_cmd,
    output avgp_pkg::t_ctrl_stat              o_stat,
    input  logic [SAMPLE_BITS-1:0]            i_sample,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [TDATA_W-1:0]                o_m_tdata,
    output logic [1:0]                        o_m_tuser,
    output logic                              o_m_tlast
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int KW  = $clog2(MAX_KERNEL + 1);
    localparam int PHW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int PW  = $clog2(MAX_WIDTH + 2 * MAX_KERNEL + 1);
    localparam int IW  = $clog2(MAX_WIDTH);
    localparam int SW  = SAMPLE_BITS + 2 * $clog2(MAX_KERNEL);
    localparam int DW  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int CB  = avgp_pkg::CFG_CHAN_BITS;
    localparam int CI  = avgp_pkg::CHAN_IDX_W;

    // configuration registers
    logic [avgp_pkg::CFG_WIDTH_BITS-1:0]  r_cfg_width;
    logic [avgp_pkg::CFG_KERNEL_BITS-1:0] r_cfg_kernel;
    logic [CB-1:0]                        r_cfg_chan;

    logic [WW-1:0] w_eff;
    logic [KW-1:0] k_eff;
    logic [CB-1:0] c_eff;
    logic [DW-1:0] r_kk;

    // position state
    logic [WW-1:0]  r_col, r_row, n_col, n_row;
    logic [PHW-1:0] r_cphase, r_rphase, n_cphase, n_rphase;
    logic [PW-1:0]  r_cbase, r_rbase, n_cbase, n_rbase;
    logic [IW-1:0]  r_oc, n_oc;
    logic [CI-1:0]  r_chan, n_chan;

    logic col_wrap, row_wrap, cph_wrap, rph_wrap, chan_wrap;
    logic col_in, row_in, col_last, row_last, chan_last;
    logic cph_end, rph_end;
    logic pos_emit, pos_span;

    // latched item
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_in_span, r_emit;
    logic                          r_eor, r_eoc, r_eof;
    logic [IW-1:0]                 r_acc_oc;
    logic signed [SW-1:0]          r_rd;
    logic                          r_rd_vld;

    // column sums, one per output column
    logic signed [SW-1:0] r_mem [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] r_vld;
    logic signed [SW-1:0] n_sum;
    logic                 wr_en;

    // divider and output register
    logic                          div_busy;
    logic signed [SAMPLE_BITS-1:0] div_q;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_avg;
    logic                          r_out_eor, r_out_eoc, r_out_eof;

    // register file; any write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= avgp_pkg::RST_INPUT_WIDTH;
            r_cfg_kernel <= avgp_pkg::RST_KERNEL_SIZE;
            r_cfg_chan   <= avgp_pkg::RST_CHANNEL_COUNT;
        end else if (i_cfg_valid) begin
            case (avgp_pkg::t_reg_idx'(i_cfg_index))
                avgp_pkg::REG_INPUT_WIDTH: begin
                    r_cfg_width <= avgp_pkg::CFG_WIDTH_BITS'(i_cfg_data);
                end
                avgp_pkg::REG_KERNEL_SIZE: begin
                    r_cfg_kernel <= avgp_pkg::CFG_KERNEL_BITS'(i_cfg_data);
                end
                avgp_pkg::REG_CHANNEL_COUNT: begin
                    r_cfg_chan <= CB'(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, oversize saturates
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_width);
        end
        if (r_cfg_kernel == '0) begin
            k_eff = KW'(1);
        end else if (32'(r_cfg_kernel) > 32'(MAX_KERNEL)) begin
            k_eff = KW'(MAX_KERNEL);
        end else begin
            k_eff = KW'(r_cfg_kernel);
        end
        if (r_cfg_chan == '0) begin
            c_eff = CB'(1);
        end else if (32'(r_cfg_chan) > 32'(avgp_pkg::MAX_CHANNELS)) begin
            c_eff = CB'(avgp_pkg::MAX_CHANNELS);
        end else begin
            c_eff = r_cfg_chan;
        end
    end

    // window area K*K, the divisor
    always_ff @(posedge i_clk) begin
        r_kk <= DW'({{KW{1'b0}}, k_eff} * {{KW{1'b0}}, k_eff});
    end

    // window membership: a window fits if its start plus K stays within the width
    always_comb begin
        col_in    = (r_cbase + PW'(k_eff)) <= PW'(w_eff);
        row_in    = (r_rbase + PW'(k_eff)) <= PW'(w_eff);
        col_last  = (r_cbase + PW'(k_eff) + PW'(k_eff)) > PW'(w_eff);
        row_last  = (r_rbase + PW'(k_eff) + PW'(k_eff)) > PW'(w_eff);
        chan_last = CB'(r_chan) == (c_eff - CB'(1));
        cph_end   = KW'(r_cphase) == (k_eff - KW'(1));
        rph_end   = KW'(r_rphase) == (k_eff - KW'(1));
        pos_span  = col_in & row_in;
        pos_emit  = pos_span & cph_end & rph_end;
    end

    // raster advance
    always_comb begin
        col_wrap  = (r_col + WW'(1)) >= w_eff;
        row_wrap  = (r_row + WW'(1)) >= w_eff;
        cph_wrap  = (KW'(r_cphase) + KW'(1)) >= k_eff;
        rph_wrap  = (KW'(r_rphase) + KW'(1)) >= k_eff;
        chan_wrap = (CB'(r_chan) + CB'(1)) >= c_eff;

        n_col    = r_col;
        n_row    = r_row;
        n_cphase = r_cphase;
        n_rphase = r_rphase;
        n_cbase  = r_cbase;
        n_rbase  = r_rbase;
        n_oc     = r_oc;
        n_chan   = r_chan;

        if (col_wrap) begin
            n_col    = '0;
            n_cphase = '0;
            n_cbase  = '0;
            n_oc     = '0;
            if (row_wrap) begin
                n_row    = '0;
                n_rphase = '0;
                n_rbase  = '0;
                n_chan   = chan_wrap ? '0 : r_chan + CI'(1);
            end else begin
                n_row = r_row + WW'(1);
                if (rph_wrap) begin
                    n_rphase = '0;
                    n_rbase  = r_rbase + PW'(k_eff);
                end else begin
                    n_rphase = r_rphase + PHW'(1);
                end
            end
        end else begin
            n_col = r_col + WW'(1);
            if (cph_wrap) begin
                n_cphase = '0;
                n_cbase  = r_cbase + PW'(k_eff);
                n_oc     = r_oc + IW'(1);
            end else begin
                n_cphase = r_cphase + PHW'(1);
            end
        end
    end

    // position counters and item control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_valid) begin
            r_col     <= '0;
            r_row     <= '0;
            r_cphase  <= '0;
            r_rphase  <= '0;
            r_cbase   <= '0;
            r_rbase   <= '0;
            r_oc      <= '0;
            r_chan    <= '0;
            r_in_span <= 1'b0;
            r_emit    <= 1'b0;
        end else if (i_cmd.accept) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_cphase  <= n_cphase;
            r_rphase  <= n_rphase;
            r_cbase   <= n_cbase;
            r_rbase   <= n_rbase;
            r_oc      <= n_oc;
            r_chan    <= n_chan;
            r_in_span <= pos_span;
            r_emit    <= pos_emit;
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= signed'(i_sample);
            r_acc_oc <= r_oc;
            r_rd_vld <= r_vld[r_oc];
            r_eor    <= col_last;
            r_eoc    <= col_last & row_last;
            r_eof    <= col_last & row_last & chan_last;
        end
    end

    // column sum update
    always_comb begin
        n_sum = (r_rd_vld ? r_rd : SW'(0)) + SW'(r_sample);
        wr_en = i_cmd.accumulate & r_in_span & !r_emit;
    end

    // sum memory: read at transfer, written back in the accumulate state that follows
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= r_mem[r_oc];
        end
        if (wr_en) begin
            r_mem[r_acc_oc] <= n_sum;
        end
    end

    // an entry without its valid bit reads as zero; emitting clears the entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_valid) begin
            r_vld <= '0;
        end else if (i_cmd.accumulate && r_in_span) begin
            r_vld[r_acc_oc] <= !r_emit;
        end
    end

    avgp_div #(
        .SW (SW),
        .DW (DW),
        .QW (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (n_sum),
        .i_divisor  (r_kk),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_avg <= div_q;
            r_out_eor <= r_eor;
            r_out_eoc <= r_eoc;
            r_out_eof <= r_eof;
        end
    end

    always_comb begin
        o_stat.emit     = r_emit;
        o_stat.div_busy = div_busy;
        o_stat.out_free = !r_out_valid | i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_W'($unsigned(r_out_avg));
    assign o_m_tuser  = {r_out_eoc, r_out_eor};
    assign o_m_tlast  = r_out_eof;

    `AVGP_ASSERT_IMPL(a_flags_nest, r_out_valid && r_out_eof, r_out_eoc && r_out_eor)
    `AVGP_ASSERT_NEXT(a_cfg_clears_sums, i_cfg_valid, r_vld == '0 && r_col == '0)
    `AVGP_ASSERT_IMPL(a_emit_in_window, r_emit, r_in_span)

endmodule
